FILE: hdl/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

    // Default width of the centre coordinates.
    localparam int COORD_BITS_DEF = 12;

    // Request kinds carried on the input tuser bit.
    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    // Multiplier operations; each one selects its operands and its target register.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_A2,
        MUL_B2,
        MUL_AB_B,
        MUL_R1_LHS,
        MUL_R1_RHS,
        MUL_R1_DX,
        MUL_R1_DY,
        MUL_SQ_X,
        MUL_SQ_Y,
        MUL_E_X,
        MUL_E_Y,
        MUL_E_AB,
        MUL_R2_DX,
        MUL_R2_DY
    } t_mul_op;

    // Updates of the walking state.
    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_START,
        UPD_R1,
        UPD_ENTER2,
        UPD_R2E,
        UPD_R2,
        UPD_STOP
    } t_upd_op;

    // What the output register is loaded with.
    typedef enum logic [2:0] {
        SEL_Q0,
        SEL_Q1,
        SEL_Q2,
        SEL_Q3,
        SEL_FIN
    } t_out_sel;

    typedef struct packed {
        logic     load;
        t_mul_op  mul_op;
        t_upd_op  upd_op;
        logic     out_load;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic region2;
        logic y_pos;
        logic r1_cond;
    } t_dp_status;

endpackage

FILE: hdl/mer_dp.sv
// Datapath of the midpoint ellipse rasterizer: shared multiplier, walk state, output register.
`timescale 1ns / 1ps

module mer_dp
    import mer_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [COORD_BITS-1:0]   i_center_x,
    input  logic [COORD_BITS-1:0]   i_center_y,
    input  logic [COORD_BITS-2:0]   i_axis_a,
    input  logic [COORD_BITS-2:0]   i_axis_b,
    output t_dp_status              o_status,
    output logic [COORD_BITS+1:0]   o_pixel_x,
    output logic [COORD_BITS+1:0]   o_pixel_y,
    output logic                    o_pixel_valid,
    output logic                    o_last,
    output logic                    o_finished
);

    localparam int AXIS_BITS = COORD_BITS - 1;
    localparam int SQ_BITS   = 2 * AXIS_BITS;
    localparam int OUT_BITS  = COORD_BITS + 2;
    localparam int MUL_W     = 2 * COORD_BITS + 3;
    localparam int D_W       = 2 * MUL_W;

    logic [COORD_BITS-1:0]   r_cx, r_cy, r_x, r_y;
    logic [AXIS_BITS-1:0]    r_a, r_b;
    logic [SQ_BITS-1:0]      r_a2, r_b2;
    logic signed [D_W-1:0]   r_d, r_t0, r_t1, r_t2, r_t3;
    logic                    r_region2, r_active;
    logic [OUT_BITS-1:0]     r_px, r_py;
    logic                    r_pvalid, r_last, r_fin;

    logic signed [MUL_W-1:0] a_e, b_e, a2_e, b2_e, x_e, y_e;
    logic signed [MUL_W-1:0] op_l, op_r;
    logic signed [D_W-1:0]   prod;
    logic signed [D_W-1:0]   a2_d, b2_d;
    logic [OUT_BITS-1:0]     cx_o, cy_o, x_o, y_o;

    assign a_e  = $signed({{(MUL_W-AXIS_BITS){1'b0}}, r_a});
    assign b_e  = $signed({{(MUL_W-AXIS_BITS){1'b0}}, r_b});
    assign a2_e = $signed({{(MUL_W-SQ_BITS){1'b0}}, r_a2});
    assign b2_e = $signed({{(MUL_W-SQ_BITS){1'b0}}, r_b2});
    assign x_e  = $signed({{(MUL_W-COORD_BITS){1'b0}}, r_x});
    assign y_e  = $signed({{(MUL_W-COORD_BITS){1'b0}}, r_y});
    assign a2_d = $signed({{(D_W-SQ_BITS){1'b0}}, r_a2});
    assign b2_d = $signed({{(D_W-SQ_BITS){1'b0}}, r_b2});

    // Operand selection for the one shared multiplier.
    always_comb begin
        op_l = '0;
        op_r = '0;
        case (i_cmd.mul_op)
            MUL_A2:     begin op_l = a_e;  op_r = a_e; end
            MUL_B2:     begin op_l = b_e;  op_r = b_e; end
            MUL_AB_B:   begin op_l = a2_e; op_r = b_e; end
            MUL_R1_LHS: begin op_l = a2_e; op_r = (y_e <<< 1) - MUL_W'(1); end
            MUL_R1_RHS: begin op_l = b2_e; op_r = x_e + MUL_W'(1); end
            MUL_R1_DX:  begin op_l = b2_e; op_r = (x_e <<< 1) + MUL_W'(3); end
            MUL_R1_DY:  begin op_l = a2_e; op_r = MUL_W'(2) - (y_e <<< 1); end
            MUL_SQ_X: begin
                op_l = (x_e <<< 1) + MUL_W'(1);
                op_r = (x_e <<< 1) + MUL_W'(1);
            end
            MUL_SQ_Y:   begin op_l = y_e - MUL_W'(1); op_r = y_e - MUL_W'(1); end
            MUL_E_X:    begin op_l = b2_e; op_r = r_t0[MUL_W-1:0]; end
            MUL_E_Y:    begin op_l = a2_e; op_r = r_t1[MUL_W-1:0]; end
            MUL_E_AB:   begin op_l = a2_e; op_r = b2_e; end
            MUL_R2_DX:  begin op_l = b2_e; op_r = (x_e <<< 1) + MUL_W'(2); end
            MUL_R2_DY:  begin op_l = a2_e; op_r = MUL_W'(3) - (y_e <<< 1); end
            default:    begin op_l = '0;   op_r = '0; end
        endcase
    end

    assign prod = op_l * op_r;

    // Product lands in its target register.
    always_ff @(posedge i_clk) begin
        case (i_cmd.mul_op)
            MUL_A2:     r_a2 <= prod[SQ_BITS-1:0];
            MUL_B2:     r_b2 <= prod[SQ_BITS-1:0];
            MUL_AB_B:   r_t0 <= prod;
            MUL_R1_LHS: r_t0 <= prod;
            MUL_R1_RHS: r_t1 <= prod;
            MUL_R1_DX:  r_t2 <= prod;
            MUL_R1_DY:  r_t3 <= prod;
            MUL_SQ_X:   r_t0 <= prod;
            MUL_SQ_Y:   r_t1 <= prod;
            MUL_E_X:    r_t0 <= prod;
            MUL_E_Y:    r_t1 <= prod;
            MUL_E_AB:   r_t2 <= prod;
            MUL_R2_DX:  r_t0 <= prod;
            MUL_R2_DY:  r_t1 <= prod;
            default:    ;
        endcase
        if (i_cmd.load) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_a  <= i_axis_a;
            r_b  <= i_axis_b;
        end
    end

    // Walk state. The decision value is four times the real midpoint decision.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region2 <= 1'b0;
            r_active  <= 1'b0;
        end else begin
            case (i_cmd.upd_op)
                UPD_START: begin
                    r_d       <= (b2_d <<< 2) - (r_t0 <<< 2) + a2_d;
                    r_x       <= '0;
                    r_y       <= {{(COORD_BITS-AXIS_BITS){1'b0}}, r_b};
                    r_region2 <= 1'b0;
                    r_active  <= 1'b1;
                end
                UPD_R1: begin
                    if (r_d[D_W-1]) begin
                        r_d <= r_d + (r_t2 <<< 2);
                    end else begin
                        r_d <= r_d + (r_t2 <<< 2) + (r_t3 <<< 2);
                        r_y <= r_y - COORD_BITS'(1);
                    end
                    r_x <= r_x + COORD_BITS'(1);
                end
                UPD_ENTER2: r_region2 <= 1'b1;
                UPD_R2E:    r_d <= r_t0 + (r_t1 <<< 2) - (r_t2 <<< 2);
                UPD_R2: begin
                    if (r_d[D_W-1]) begin
                        r_d <= r_d + (r_t0 <<< 2) + (r_t1 <<< 2);
                        r_x <= r_x + COORD_BITS'(1);
                    end else begin
                        r_d <= r_d + (r_t1 <<< 2);
                    end
                    r_y <= r_y - COORD_BITS'(1);
                end
                UPD_STOP:   r_active <= 1'b0;
                default:    ;
            endcase
        end
    end

    assign o_status.active  = r_active;
    assign o_status.region2 = r_region2;
    assign o_status.y_pos   = |r_y;
    assign o_status.r1_cond = r_t0 > (r_t1 <<< 1);

    assign cx_o = {2'b00, r_cx};
    assign cy_o = {2'b00, r_cy};
    assign x_o  = {2'b00, r_x};
    assign y_o  = {2'b00, r_y};

    // Output register: one of the four mirrored points, or the finished marker.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pvalid <= (i_cmd.out_sel != SEL_FIN);
            r_last   <= (i_cmd.out_sel == SEL_Q3) || (i_cmd.out_sel == SEL_FIN);
            r_fin    <= (i_cmd.out_sel == SEL_FIN);
            case (i_cmd.out_sel)
                SEL_Q0:  begin r_px <= cx_o + x_o; r_py <= cy_o + y_o; end
                SEL_Q1:  begin r_px <= cx_o - x_o; r_py <= cy_o + y_o; end
                SEL_Q2:  begin r_px <= cx_o - x_o; r_py <= cy_o - y_o; end
                SEL_Q3:  begin r_px <= cx_o + x_o; r_py <= cy_o - y_o; end
                default: begin r_px <= '0;         r_py <= '0;         end
            endcase
        end
    end

    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_valid = r_pvalid;
    assign o_last        = r_last;
    assign o_finished    = r_fin;

endmodule

FILE: hdl/mer_ctrl.sv
// Controller of the midpoint ellipse rasterizer: sequences multiplies, updates and emission.
`timescale 1ns / 1ps

module mer_ctrl
    import mer_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_cmd       i_in_cmd,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_A2, S_B2, S_AB, S_START_UPD,
        S_R1_LHS, S_R1_RHS, S_R1_DX, S_R1_DY, S_R1_UPD,
        S_SQ_X, S_SQ_Y, S_E_X, S_E_Y, S_E_AB, S_R2E_UPD,
        S_R2_CHK, S_R2_DX, S_R2_DY, S_R2_UPD,
        S_EMIT, S_FIN
    } t_state;

    t_state     r_state;
    logic       r_in_ready;
    logic       r_out_valid;
    logic [1:0] r_quad;
    logic       accept;
    logic       slot_free;

    assign accept    = i_in_valid && r_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_op   = MUL_NONE;
        o_cmd.upd_op   = UPD_NONE;
        o_cmd.out_sel  = SEL_Q0;
        case (r_state)
            S_IDLE:      o_cmd.load = accept && (i_in_cmd == CMD_START);
            S_A2:        o_cmd.mul_op = MUL_A2;
            S_B2:        o_cmd.mul_op = MUL_B2;
            S_AB:        o_cmd.mul_op = MUL_AB_B;
            S_START_UPD: o_cmd.upd_op = UPD_START;
            S_R1_LHS:    o_cmd.mul_op = MUL_R1_LHS;
            S_R1_RHS:    o_cmd.mul_op = MUL_R1_RHS;
            S_R1_DX:     o_cmd.mul_op = MUL_R1_DX;
            S_R1_DY:     o_cmd.mul_op = MUL_R1_DY;
            S_R1_UPD:    o_cmd.upd_op = i_status.r1_cond ? UPD_R1 : UPD_ENTER2;
            S_SQ_X:      o_cmd.mul_op = MUL_SQ_X;
            S_SQ_Y:      o_cmd.mul_op = MUL_SQ_Y;
            S_E_X:       o_cmd.mul_op = MUL_E_X;
            S_E_Y:       o_cmd.mul_op = MUL_E_Y;
            S_E_AB:      o_cmd.mul_op = MUL_E_AB;
            S_R2E_UPD:   o_cmd.upd_op = UPD_R2E;
            S_R2_CHK:    o_cmd.upd_op = i_status.y_pos ? UPD_NONE : UPD_STOP;
            S_R2_DX:     o_cmd.mul_op = MUL_R2_DX;
            S_R2_DY:     o_cmd.mul_op = MUL_R2_DY;
            S_R2_UPD:    o_cmd.upd_op = UPD_R2;
            S_EMIT: begin
                o_cmd.out_load = slot_free;
                o_cmd.out_sel  = t_out_sel'({1'b0, r_quad});
            end
            S_FIN: begin
                o_cmd.out_load = slot_free;
                o_cmd.out_sel  = SEL_FIN;
            end
            default:     ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
            r_quad      <= '0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in_ready <= 1'b0;
                        if (i_in_cmd == CMD_START) begin
                            r_state <= S_A2;
                        end else if (!i_status.active) begin
                            r_state <= S_FIN;
                        end else if (i_status.region2) begin
                            r_state <= S_R2_CHK;
                        end else begin
                            r_state <= S_R1_LHS;
                        end
                    end
                end
                S_A2:        r_state <= S_B2;
                S_B2:        r_state <= S_AB;
                S_AB:        r_state <= S_START_UPD;
                S_START_UPD: r_state <= S_EMIT;
                S_R1_LHS:    r_state <= S_R1_RHS;
                S_R1_RHS:    r_state <= S_R1_DX;
                S_R1_DX:     r_state <= S_R1_DY;
                S_R1_DY:     r_state <= S_R1_UPD;
                S_R1_UPD:    r_state <= i_status.r1_cond ? S_EMIT : S_SQ_X;
                S_SQ_X:      r_state <= S_SQ_Y;
                S_SQ_Y:      r_state <= S_E_X;
                S_E_X:       r_state <= S_E_Y;
                S_E_Y:       r_state <= S_E_AB;
                S_E_AB:      r_state <= S_R2E_UPD;
                S_R2E_UPD:   r_state <= S_R2_CHK;
                S_R2_CHK:    r_state <= i_status.y_pos ? S_R2_DX : S_FIN;
                S_R2_DX:     r_state <= S_R2_DY;
                S_R2_DY:     r_state <= S_R2_UPD;
                S_R2_UPD:    r_state <= S_EMIT;
                S_EMIT: begin
                    if (slot_free) begin
                        r_quad <= r_quad + 2'd1;
                        if (r_quad == 2'd3) begin
                            r_state    <= S_IDLE;
                            r_in_ready <= 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    if (slot_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/midpoint_ellipse_raster.sv
// Top level of the midpoint ellipse rasterizer: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Axis-aligned midpoint ellipse rasterizer. A start request (tuser = 0) latches the
// centre and the semi-axes a and b, places the walk at x = 0, y = b, and returns the
// four mirrored points. Each step request (tuser = 1) advances the walk by one point,
// in region 1 while the slope is shallow and in region 2 afterwards, and returns four
// points in the order (+x,+y), (-x,+y), (-x,-y), (+x,-y); the fourth carries tlast.
// Points that coincide on the axes are repeated. A step after the walk reaches y = 0,
// or before any start, returns a single result with the finished flag and tlast set.
// The block handles one request at a time, and its pace is set by the single shared
// multiplier and the four serial results: a start squares a and b, forms a^2*b and
// updates the walk; a region 1 step runs its slope test and increment multiplies and an
// update; a region 2 step checks y, runs its increment multiplies and updates; the step
// that crosses into region 2 adds the region 2 setup multiplies before its region 2 step.
// Each then emits its four points, and the output side can stall the emission. A finished
// request comes from idle when the walk is inactive, or from a region 2 y check that finds
// y at zero. The next request is accepted while the last result still waits in the output register.
// Coordinates come out as two's complement, two bits wider than the centre.
module midpoint_ellipse_raster
    import mer_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // center_x, center_y, semi_axis_a, semi_axis_b from the lowest bit up
    input  logic [((4*COORD_BITS-2+7)/8)*8-1:0]    s_axis_tdata,
    // cmd: 0 = start a new ellipse, 1 = advance one step
    input  logic [0:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // pixel_x, pixel_y from the lowest bit up
    output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0]  m_axis_tdata,
    // pixel_valid, finished from the lowest bit up
    output logic [1:0]                             m_axis_tuser,
    // last_of_step
    output logic                                   m_axis_tlast
);

    localparam int AXIS_BITS = COORD_BITS - 1;
    localparam int OUT_BITS  = COORD_BITS + 2;
    localparam int OUT_TD_W  = ((2*OUT_BITS+7)/8)*8;

    t_dp_cmd               dp_cmd;
    t_dp_status            dp_status;
    t_cmd                  in_cmd;
    logic [OUT_BITS-1:0]   pixel_x, pixel_y;
    logic                  pixel_valid, last_of_step, finished;

    assign in_cmd = t_cmd'(s_axis_tuser);

    mer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (in_cmd),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // The field slices follow the packing listed beside s_axis_tdata.
    mer_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_center_x    (s_axis_tdata[COORD_BITS-1:0]),
        .i_center_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_axis_a      (s_axis_tdata[2*COORD_BITS+AXIS_BITS-1:2*COORD_BITS]),
        .i_axis_b      (s_axis_tdata[2*COORD_BITS+2*AXIS_BITS-1:2*COORD_BITS+AXIS_BITS]),
        .o_status      (dp_status),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_pixel_valid (pixel_valid),
        .o_last        (last_of_step),
        .o_finished    (finished)
    );

    assign m_axis_tdata = OUT_TD_W'({pixel_y, pixel_x});
    assign m_axis_tuser = {finished, pixel_valid};
    assign m_axis_tlast = last_of_step;

    // A finished result never carries a point and always closes its request.
    a_fin_closes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
        else $error("finished result without tlast or with pixel_valid");

    // Only one request is in work at a time.
    a_one_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready stayed high after an accepted request");

    // A start request arms the walk once its setup multiplies are done.
    a_start_arms : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_START))
        |-> ##5 dp_status.active)
        else $error("start request did not make the walk active");

endmodule
